// ===== sv/efr_pkg.sv =====
// shared types and constants of the escaped frame receiver
package efr_pkg;

	localparam int BUFFER_BYTES_DEF = 64;
	localparam int BYTE_W = 8;
	localparam int INDEX_W = 6;
	localparam int LEFT_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int SHIFT_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_MASK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_SHIFT = 2'd3;

	localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd43;
	localparam logic [BYTE_W-1:0] FAST_BITS_RST = 8'd192;
	localparam logic [BYTE_W-1:0] FAST_MASK_RST = 8'd48;
	localparam logic [SHIFT_W-1:0] FAST_SHIFT_RST = 3'd3;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_OK,
		EV_CSUM,
		EV_LONG
	} efr_event_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_char;
		logic [BYTE_W-1:0] fast_cmd_bits;
		logic [BYTE_W-1:0] fast_len_mask;
		logic [SHIFT_W-1:0] fast_len_shift;
	} efr_cfg_t;

endpackage

// ===== sv/efr_if.sv =====
// channel interfaces: received bytes, results and configuration writes
interface efr_byte_if;
	logic valid;
	logic ready;
	logic [efr_pkg::BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_res_if;
	logic valid;
	logic ready;
	logic store_valid;
	logic [efr_pkg::INDEX_W-1:0] store_index;
	logic [efr_pkg::BYTE_W-1:0] store_byte;
	logic [1:0] frame_event;
	modport source (output valid, output store_valid, output store_index,
		output store_byte, output frame_event, input ready);
	modport sink (input valid, input store_valid, input store_index,
		input store_byte, input frame_event, output ready);
endinterface

interface efr_cfg_if;
	logic valid;
	logic ready;
	logic [efr_pkg::CFG_IDX_W-1:0] index;
	logic [efr_pkg::BYTE_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/efr_cfg_regs.sv =====
// configuration register file
module efr_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	efr_cfg_if.sink cfg,
	output efr_pkg::efr_cfg_t regs
);

	efr_pkg::efr_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_char <= efr_pkg::START_CHAR_RST;
			regs_q.fast_cmd_bits <= efr_pkg::FAST_BITS_RST;
			regs_q.fast_len_mask <= efr_pkg::FAST_MASK_RST;
			regs_q.fast_len_shift <= efr_pkg::FAST_SHIFT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				efr_pkg::CFG_START_CHAR: regs_q.start_char <= cfg.data;
				efr_pkg::CFG_FAST_BITS: regs_q.fast_cmd_bits <= cfg.data;
				efr_pkg::CFG_FAST_MASK: regs_q.fast_len_mask <= cfg.data;
				efr_pkg::CFG_FAST_SHIFT: begin
					regs_q.fast_len_shift <= cfg.data[efr_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/efr_in_stage.sv =====
// input register stage for received bytes
module efr_in_stage (
	input  logic clk,
	input  logic arst_n,
	efr_byte_if.sink rx,
	input  logic take,
	output logic valid_s1,
	output logic [efr_pkg::BYTE_W-1:0] byte_s1
);

	logic full_s1;

	assign rx.ready = !full_s1 || take;
	assign valid_s1 = full_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_s1 <= 1'b0;
		end else if (rx.ready) begin
			full_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// ===== sv/efr_deframe.sv =====
// frame decoding state and result register
module efr_deframe #(
	parameter int BUFFER_BYTES = efr_pkg::BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  efr_pkg::efr_cfg_t regs,
	input  logic valid_s1,
	input  logic [efr_pkg::BYTE_W-1:0] byte_s1,
	output logic take,
	efr_res_if.source res
);

	localparam int WPOS_W = $clog2(BUFFER_BYTES + 1);
	localparam int LW = efr_pkg::LEFT_W;
	localparam int BW = efr_pkg::BYTE_W;

	logic start_seen_q, expect_length_q, overflowed_q;
	logic [LW-1:0] bytes_left_q;
	logic [BW-1:0] running_sum_q;
	logic [WPOS_W-1:0] write_pos_q;

	logic n_start_seen, n_expect_length, n_overflowed;
	logic [LW-1:0] n_bytes_left, left, left_dec;
	logic [BW-1:0] n_running_sum;
	logic [WPOS_W-1:0] n_write_pos;

	logic hit, ss, fast;
	logic r_store_valid;
	logic [efr_pkg::INDEX_W-1:0] r_store_index;
	logic [BW-1:0] r_store_byte;
	efr_pkg::efr_event_t r_event;

	logic res_valid_q, store_valid_q;
	logic [efr_pkg::INDEX_W-1:0] store_index_q;
	logic [BW-1:0] store_byte_q;
	efr_pkg::efr_event_t event_q;

	assign take = valid_s1 && (!res_valid_q || res.ready);

	always_comb begin
		n_start_seen = start_seen_q;
		n_expect_length = expect_length_q;
		n_overflowed = overflowed_q;
		n_bytes_left = bytes_left_q;
		n_running_sum = running_sum_q;
		n_write_pos = write_pos_q;
		r_store_valid = 1'b0;
		r_store_index = '0;
		r_store_byte = '0;
		r_event = efr_pkg::EV_NONE;
		left = bytes_left_q;
		left_dec = bytes_left_q - LW'(1);
		hit = (byte_s1 == regs.start_char);
		ss = start_seen_q ^ hit;
		fast = ((byte_s1 & regs.fast_cmd_bits) == regs.fast_cmd_bits);
		if (hit && ss) begin
			n_start_seen = 1'b1;
		end else if (ss) begin
			// command byte opens a frame
			n_start_seen = 1'b0;
			r_store_valid = 1'b1;
			r_store_byte = byte_s1;
			n_write_pos = WPOS_W'(1);
			n_overflowed = 1'b0;
			n_running_sum = byte_s1;
			n_expect_length = !fast;
			n_bytes_left = fast
				? LW'((byte_s1 & regs.fast_len_mask) >> regs.fast_len_shift) + LW'(1)
				: '0;
		end else begin
			n_start_seen = 1'b0;
			if (expect_length_q) begin
				left = LW'(byte_s1) + LW'(2);
				n_expect_length = 1'b0;
			end
			left_dec = left - LW'(1);
			n_bytes_left = left;
			if (left != '0) begin
				n_running_sum = running_sum_q + byte_s1;
				n_bytes_left = left_dec;
				if (left_dec == '0) begin
					if (overflowed_q) begin
						r_event = efr_pkg::EV_LONG;
					end else if (n_running_sum != '0) begin
						r_event = efr_pkg::EV_CSUM;
					end else begin
						r_event = efr_pkg::EV_OK;
					end
				end else if (!overflowed_q) begin
					if (write_pos_q < WPOS_W'(BUFFER_BYTES)) begin
						r_store_valid = 1'b1;
						r_store_index = efr_pkg::INDEX_W'(write_pos_q);
						r_store_byte = byte_s1;
						n_write_pos = write_pos_q + WPOS_W'(1);
					end else begin
						n_overflowed = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seen_q <= 1'b0;
			expect_length_q <= 1'b0;
			overflowed_q <= 1'b0;
			bytes_left_q <= '0;
			running_sum_q <= '0;
			write_pos_q <= '0;
			res_valid_q <= 1'b0;
		end else if (take) begin
			start_seen_q <= n_start_seen;
			expect_length_q <= n_expect_length;
			overflowed_q <= n_overflowed;
			bytes_left_q <= n_bytes_left;
			running_sum_q <= n_running_sum;
			write_pos_q <= n_write_pos;
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_valid_q <= r_store_valid;
			store_index_q <= r_store_index;
			store_byte_q <= r_store_byte;
			event_q <= r_event;
		end
	end

	assign res.valid = res_valid_q;
	assign res.store_valid = store_valid_q;
	assign res.store_index = store_index_q;
	assign res.store_byte = store_byte_q;
	assign res.frame_event = event_q;

endmodule

// ===== sv/escaped_frame_receiver.sv =====
// top level of the escaped frame receiver
//
//  channel  modport  transaction
//  rx       sink     one received serial byte
//  res      source   store flag, index, byte and frame event
//  cfg      sink     register index and write data
//
// one byte per cycle sustained while res is ready; an rx transaction reaches the result
// through the input register and the result register around the decode logic
// arst_n clears decode state, handshake flags and registers to defaults
// a stalled result holds the input register; rx.ready drops only when both are full
// cfg is always ready
module escaped_frame_receiver #(
	parameter int BUFFER_BYTES = efr_pkg::BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	efr_byte_if.sink rx,
	efr_res_if.source res,
	efr_cfg_if.sink cfg
);

	efr_pkg::efr_cfg_t regs;
	logic take, valid_s1;
	logic [efr_pkg::BYTE_W-1:0] byte_s1;

	efr_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	efr_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.take(take),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1)
	);

	efr_deframe #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_deframe (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1),
		.take(take),
		.res(res)
	);

endmodule

// ===== sv/efr_checker.sv =====
// port checker for the escaped frame receiver and its bind
module efr_checker (
	input logic clk,
	input logic arst_n,
	input logic rx_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_store_valid,
	input logic [efr_pkg::INDEX_W-1:0] res_store_index,
	input logic [efr_pkg::BYTE_W-1:0] res_store_byte,
	input logic [1:0] res_frame_event
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_store_valid)
			&& $stable(res_store_index) && $stable(res_store_byte)
			&& $stable(res_frame_event))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> res_valid && !res_ready)
		else $error("rx stalled without a stalled result");

	a_event_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_frame_event != efr_pkg::EV_NONE |-> !res_store_valid)
		else $error("frame event together with a store");

	a_no_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_store_valid |-> res_store_index == '0 && res_store_byte == '0)
		else $error("nonzero fields without a store");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_ready(rx.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_store_valid(res.store_valid),
	.res_store_index(res.store_index),
	.res_store_byte(res.store_byte),
	.res_frame_event(res.frame_event)
);

// ===== verif/tb_escaped_frame_receiver.sv =====
`timescale 1ns / 100ps
// testbench for the escaped frame receiver: framed byte streams against a predictor
module tb_escaped_frame_receiver;

	localparam int BUF_BYTES = efr_pkg::BUFFER_BYTES_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [efr_pkg::BYTE_W-1:0] DEF_START = efr_pkg::START_CHAR_RST;

	typedef struct packed {
		logic store_valid;
		logic [efr_pkg::INDEX_W-1:0] store_index;
		logic [efr_pkg::BYTE_W-1:0] store_byte;
		efr_pkg::efr_event_t frame_event;
	} deframe_out_t;

	class frame_tracker;
		efr_pkg::efr_cfg_t cfg;
		bit start_seen;
		bit expect_length;
		bit overflowed;
		logic [efr_pkg::LEFT_W-1:0] bytes_left;
		logic [efr_pkg::BYTE_W-1:0] running_sum;
		int unsigned write_pos;
		deframe_out_t byte_outcomes[$];
		int mismatches;

		function new();
			cfg = '{efr_pkg::START_CHAR_RST, efr_pkg::FAST_BITS_RST,
				efr_pkg::FAST_MASK_RST, efr_pkg::FAST_SHIFT_RST};
			start_seen = 1'b0;
			expect_length = 1'b0;
			overflowed = 1'b0;
			bytes_left = '0;
			running_sum = '0;
			write_pos = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [efr_pkg::CFG_IDX_W-1:0] idx,
				logic [efr_pkg::BYTE_W-1:0] data);
			case (idx)
				efr_pkg::CFG_START_CHAR: cfg.start_char = data;
				efr_pkg::CFG_FAST_BITS: cfg.fast_cmd_bits = data;
				efr_pkg::CFG_FAST_MASK: cfg.fast_len_mask = data;
				efr_pkg::CFG_FAST_SHIFT: cfg.fast_len_shift = data[efr_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_rx_byte(logic [efr_pkg::BYTE_W-1:0] b);
			deframe_out_t r;
			logic [efr_pkg::BYTE_W-1:0] field;
			bit handled;
			r = '{1'b0, '0, '0, efr_pkg::EV_NONE};
			handled = 1'b0;
			if (b == cfg.start_char) begin
				start_seen = !start_seen;
				handled = start_seen;
			end
			// command byte opens a frame, also when one is still open
			if (!handled && start_seen) begin
				r.store_valid = 1'b1;
				r.store_byte = b;
				write_pos = 1;
				overflowed = 1'b0;
				running_sum = b;
				bytes_left = '0;
				expect_length = 1'b1;
				if ((b & cfg.fast_cmd_bits) == cfg.fast_cmd_bits) begin
					field = (b & cfg.fast_len_mask) >> cfg.fast_len_shift;
					expect_length = 1'b0;
					bytes_left = efr_pkg::LEFT_W'(field) + efr_pkg::LEFT_W'(1);
				end
				start_seen = 1'b0;
				handled = 1'b1;
			end
			if (!handled) begin
				if (expect_length) begin
					bytes_left = efr_pkg::LEFT_W'(b) + efr_pkg::LEFT_W'(2);
					expect_length = 1'b0;
				end
				if (bytes_left != '0) begin
					running_sum = running_sum + b;
					bytes_left = bytes_left - efr_pkg::LEFT_W'(1);
					if (bytes_left == '0) begin
						if (overflowed)
							r.frame_event = efr_pkg::EV_LONG;
						else if (running_sum != '0)
							r.frame_event = efr_pkg::EV_CSUM;
						else
							r.frame_event = efr_pkg::EV_OK;
					end else if (!overflowed) begin
						if (write_pos < BUF_BYTES) begin
							r.store_valid = 1'b1;
							r.store_index = write_pos[efr_pkg::INDEX_W-1:0];
							r.store_byte = b;
							write_pos++;
						end else begin
							overflowed = 1'b1;
						end
					end
				end
			end
			byte_outcomes.push_back(r);
		endfunction

		function void check_store_result(deframe_out_t got);
			deframe_out_t want;
			if (byte_outcomes.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result valid %0b index %0d byte %02h event %0d",
						$time, got.store_valid, got.store_index, got.store_byte,
						got.frame_event);
				mismatches++;
				return;
			end
			want = byte_outcomes.pop_front();
			if (got.store_valid !== want.store_valid || got.store_index !== want.store_index ||
					got.store_byte !== want.store_byte ||
					got.frame_event !== want.frame_event) begin
				if (mismatches < 10)
					$display({"%0t: expected valid %0b index %0d byte %02h event %0d,",
						" got %0b %0d %02h %0d"},
						$time, want.store_valid, want.store_index, want.store_byte,
						want.frame_event, got.store_valid, got.store_index,
						got.store_byte, got.frame_event);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	efr_byte_if rx_if();
	efr_res_if res_if();
	efr_cfg_if cfg_if();

	frame_tracker tracker = new();
	deframe_out_t seen_out;
	logic [efr_pkg::BYTE_W-1:0] line_q[$];
	bit calm;
	int burst_left;
	int quiet_cycles = 0;
	logic [15:0] stall_pat;
	logic [3:0] pat_pos;

	escaped_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		res_if.ready = 1'b0;
		stall_pat = '1;
		pat_pos = '0;
		forever begin
			@(negedge clk);
			if (pat_pos == '0)
				stall_pat = 16'($urandom | $urandom);
			res_if.ready <= calm || stall_pat[pat_pos];
			pat_pos = pat_pos + 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				tracker.note_rx_byte(rx_if.rx_byte);
			if (res_if.valid && res_if.ready) begin
				seen_out.store_valid = res_if.store_valid;
				seen_out.store_index = res_if.store_index;
				seen_out.store_byte = res_if.store_byte;
				seen_out.frame_event = efr_pkg::efr_event_t'(res_if.frame_event);
				tracker.check_store_result(seen_out);
			end
			if (cfg_if.valid && cfg_if.ready)
				tracker.write_reg(cfg_if.index, cfg_if.data);
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [efr_pkg::BYTE_W-1:0] b);
		int idle;
		if (burst_left == 0) begin
			idle = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			if (idle > 0) begin
				@(negedge clk);
				rx_if.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		@(negedge clk);
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		burst_left--;
	endtask

	task automatic drive_line();
		foreach (line_q[i])
			send_byte(line_q[i]);
		line_q.delete();
	endtask

	task automatic settle();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (tracker.byte_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [efr_pkg::CFG_IDX_W-1:0] idx,
			input logic [efr_pkg::BYTE_W-1:0] data);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [efr_pkg::BYTE_W-1:0] sc,
			input logic [efr_pkg::BYTE_W-1:0] bits,
			input logic [efr_pkg::BYTE_W-1:0] mask,
			input logic [efr_pkg::SHIFT_W-1:0] shift);
		settle();
		set_reg(efr_pkg::CFG_START_CHAR, sc);
		set_reg(efr_pkg::CFG_FAST_BITS, bits);
		set_reg(efr_pkg::CFG_FAST_MASK, mask);
		// upper bits of the shift write are don't-care
		set_reg(efr_pkg::CFG_FAST_SHIFT, {5'($urandom), shift});
	endtask

	function automatic int pick_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return $urandom_range(0, 8);
		if (roll < 92)
			return $urandom_range(9, 40);
		return $urandom_range(55, 70);
	endfunction

	function automatic void queue_frame(bit want_fast, int data_len, bit bad_sum, bit cut_short);
		logic [efr_pkg::BYTE_W-1:0] sc;
		logic [efr_pkg::BYTE_W-1:0] bits;
		logic [efr_pkg::BYTE_W-1:0] cmd;
		logic [efr_pkg::BYTE_W-1:0] sum;
		logic [efr_pkg::BYTE_W-1:0] fld;
		logic [efr_pkg::BYTE_W-1:0] body[$];
		int n;
		int tries;
		sc = tracker.cfg.start_char;
		bits = tracker.cfg.fast_cmd_bits;
		tries = 0;
		cmd = 8'($urandom);
		if (want_fast) begin
			cmd = cmd | bits;
			while (cmd == sc && tries < 40) begin
				cmd = 8'($urandom) | bits;
				tries++;
			end
		end else begin
			while (((cmd & bits) == bits || cmd == sc) && tries < 40) begin
				cmd = 8'($urandom);
				tries++;
			end
		end
		sum = cmd;
		if ((cmd & bits) == bits) begin
			fld = (cmd & tracker.cfg.fast_len_mask) >> tracker.cfg.fast_len_shift;
			n = fld;
		end else begin
			n = data_len;
			body.push_back(8'(n));
			sum += 8'(n);
		end
		repeat (n) begin
			fld = ($urandom_range(0, 7) == 0) ? sc : 8'($urandom);
			body.push_back(fld);
			sum += fld;
		end
		fld = 8'd0 - sum;
		if (bad_sum)
			fld = fld + 8'($urandom_range(1, 255));
		body.push_back(fld);
		if (cut_short)
			repeat ($urandom_range(1, body.size())) void'(body.pop_back());
		line_q.push_back(sc);
		line_q.push_back(cmd);
		foreach (body[i]) begin
			if (body[i] == sc)
				line_q.push_back(sc);
			line_q.push_back(body[i]);
		end
	endfunction

	task automatic run_random(input int budget);
		int sent;
		int roll;
		bit is_noise;
		logic [efr_pkg::BYTE_W-1:0] b;
		sent = 0;
		while (sent < budget) begin
			roll = $urandom_range(0, 99);
			is_noise = 1'b0;
			if (roll < 66) begin
				queue_frame($urandom_range(0, 1), pick_len(), 1'b0, 1'b0);
			end else if (roll < 78) begin
				queue_frame($urandom_range(0, 1), pick_len(), 1'b1, 1'b0);
			end else if (roll < 90) begin
				queue_frame($urandom_range(0, 1), pick_len(), $urandom_range(0, 1), 1'b1);
			end else begin
				is_noise = 1'b1;
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 3) == 0) begin
						line_q.push_back(tracker.cfg.start_char);
						line_q.push_back(tracker.cfg.start_char);
					end else begin
						b = 8'($urandom);
						if (b == tracker.cfg.start_char)
							b = ~b;
						line_q.push_back(b);
					end
				end
			end
			if (!is_noise)
				sent += line_q.size();
			drive_line();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = efr_pkg::CFG_START_CHAR;
		cfg_if.data = '0;
		calm = 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// idle bytes, literal start outside a frame, zero-length fast frame,
		// escaped data, bad checksum, restart inside a frame
		line_q = '{8'h00, 8'hFF, DEF_START, DEF_START,
			DEF_START, 8'hC0, 8'h40,
			DEF_START, 8'h05, 8'h02, DEF_START, DEF_START, 8'hFF, 8'hCF,
			DEF_START, 8'hD0, 8'h01, 8'h02, 8'h2E,
			DEF_START, 8'h01, 8'h05, 8'h11, DEF_START, 8'hC0, 8'h40};
		drive_line();

		// longest length byte runs past the buffer
		queue_frame(1'b0, 255, 1'b0, 1'b0);
		drive_line();
		run_random(30);

		set_config(8'h00, 8'hFF, 8'h0F, 3'd0);
		run_random(30);

		calm = 1'b1;
		set_config(8'hFF, 8'h00, 8'h00, 3'd7);
		run_random(25);

		calm = 1'b0;
		set_config(8'($urandom), 8'($urandom) | 8'h80, 8'hFF, 3'($urandom_range(4, 7)));
		run_random(30);

		settle();
		if (tracker.mismatches == 0 && tracker.byte_outcomes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
